### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset
`define ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/ncu_pkg.sv
// Shared types and constants of the coordinate update block
`default_nettype none
package ncu_pkg;

  localparam logic [31:0] COORD_ONE = 32'h0001_0000;
  localparam logic [23:0] ERROR_ONE = 24'h01_0000;
  localparam logic [16:0] GAIN_ONE  = 17'h1_0000;
  localparam logic [16:0] GAIN_RST  = 17'h0_4000;

  localparam logic [7:0] REG_ERROR_GAIN    = 8'd0;
  localparam logic [7:0] REG_MOVE_FRACTION = 8'd1;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic        go;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/ncu_ifs.sv
// Channel interfaces: sample input, result output, register write
`default_nettype none
interface ncu_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] round_trip;
  logic signed [31:0] remote_x;
  logic signed [31:0] remote_y;
  logic        [23:0] remote_error;
  modport source(output valid, round_trip, remote_x, remote_y, remote_error, input ready);
  modport sink(input valid, round_trip, remote_x, remote_y, remote_error, output ready);
endinterface

interface ncu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic        [23:0] local_error;
  logic               zero_rtt;
  modport source(output valid, local_x, local_y, local_error, zero_rtt, input ready);
  modport sink(input valid, local_x, local_y, local_error, zero_rtt, output ready);
endinterface

interface ncu_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [16:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/ncu_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide, integer root
`default_nettype none
module ncu_alu
  import ncu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  alu_op_t     op_r;
  logic        run_r;
  logic        done_r;
  logic [63:0] acc_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [6:0]  cnt_r;
  logic [63:0] res_r;

  logic [64:0] sh;
  logic        ge;
  logic [64:0] sub;
  logic [63:0] rb;
  logic        fin;

  always_comb begin
    sh  = {acc_r, a_r[63]};
    sub = sh - {1'b0, b_r};
    ge  = (sh >= {1'b0, b_r});
    rb  = a_r + b_r;
    case (op_r)
      ALU_MUL:  fin = (b_r == 64'd0);
      ALU_DIV:  fin = (cnt_r == 7'd0);
      ALU_SQRT: fin = (b_r == 64'd0);
      default:  fin = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        op_r  <= req.op;
        run_r <= 1'b1;
        cnt_r <= 7'd64;
        case (req.op)
          ALU_MUL: begin
            acc_r <= 64'd0;
            a_r   <= req.a;
            b_r   <= req.b;
          end
          ALU_DIV: begin
            acc_r <= 64'd0;
            a_r   <= req.a;
            b_r   <= req.b;
          end
          default: begin
            acc_r <= req.a;
            a_r   <= 64'd0;
            b_r   <= 64'h4000_0000_0000_0000;
          end
        endcase
      end else if (run_r) begin
        if (fin) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          res_r  <= (op_r == ALU_MUL) ? acc_r : a_r;
        end else begin
          case (op_r)
            ALU_MUL: begin
              if (b_r[0]) acc_r <= acc_r + a_r;
              a_r <= {a_r[62:0], 1'b0};
              b_r <= {1'b0, b_r[63:1]};
            end
            ALU_DIV: begin
              acc_r <= ge ? sub[63:0] : sh[63:0];
              a_r   <= {a_r[62:0], ge};
              cnt_r <= cnt_r - 7'd1;
            end
            default: begin
              if (acc_r >= rb) begin
                acc_r <= acc_r - rb;
                a_r   <= {1'b0, a_r[63:1]} + b_r;
              end else begin
                a_r <= {1'b0, a_r[63:1]};
              end
              b_r <= {2'b00, b_r[63:2]};
            end
          endcase
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule
`default_nettype wire

### hw/rtl/network_coordinate_update.sv
// Top level: 2-D network coordinate update sequencer
//
// One round-trip sample enters on in_ch (valid/ready); one result leaves
// on out_ch carrying the updated local coordinate and error estimate.
// Gains Ce and Cc are written on cfg_ch (index 0 and 1), which is always
// ready; write them only while no sample is in flight.
// A sample is taken only when the block is idle. All multiplies, divides
// and the root run on one shared iterative unit. A full update (up to
// four divides, one root, up to nine multiplies) puts its result out once
// the last step is done; a zero round trip puts it out the next cycle.
// The result holds on out_ch until taken; while the receiver stalls no
// new sample is accepted.
// Reset sets the coordinate to (1.0, 1.0), the error to 1.0 and both
// gains to 0.25.
`default_nettype none
module network_coordinate_update
  import ncu_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  ncu_in_if.sink   in_ch,
  ncu_out_if.source out_ch,
  ncu_cfg_if.sink  cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVW, S_SQX, S_SQY, S_SQRT, S_DIVR, S_MCW, S_ME1, S_ME2,
    S_MDT, S_DUX, S_DUY, S_MM, S_MMX, S_MMY, S_RESP
  } state_t;

  state_t state_r;
  logic   issued_r;

  logic signed [31:0] x_r, y_r;
  logic        [23:0] e_r;
  logic        [16:0] ce_r, cc_r;
  logic               zero_r;

  logic [15:0] rtt_r;
  logic [23:0] ej_r;
  logic [16:0] w_r, cw_r, dt_r;
  logic        dxn_r, dyn_r, big_r, dn_r;
  logic [31:0] ax_r, ay_r;
  logic [63:0] sq_r;
  logic [32:0] dist_r;
  logic [33:0] dm_r;
  logic [23:0] rel_r;
  logic [41:0] t1_r;
  logic [17:0] ux_r, uy_r;
  logic [35:0] m_r;

  alu_req_t req;
  alu_rsp_t rsp;

  logic [32:0] dx_c, dy_c, adx_c, ady_c;
  logic [24:0] s_c;
  logic [31:0] hx_c, hy_c;
  logic [32:0] dist_c;
  logic [34:0] diff_c;
  logic [42:0] esum_c;
  logic [37:0] mx_c;
  logic [16:0] gce_c, gcc_c;

  function automatic logic signed [31:0] step_sat(input logic signed [31:0] c,
                                                  input logic neg,
                                                  input logic [37:0] mag);
    logic signed [39:0] sum;
    sum = neg ? ({{8{c[31]}}, c} - {2'b00, mag}) : ({{8{c[31]}}, c} + {2'b00, mag});
    if (sum > 40'sh00_7FFF_FFFF)       step_sat = 32'sh7FFF_FFFF;
    else if (sum < -40'sh00_8000_0000) step_sat = -32'sh8000_0000;
    else                               step_sat = sum[31:0];
  endfunction

  always_comb begin
    dx_c   = {x_r[31], x_r} - {in_ch.remote_x[31], in_ch.remote_x};
    dy_c   = {y_r[31], y_r} - {in_ch.remote_y[31], in_ch.remote_y};
    adx_c  = dx_c[32] ? -dx_c : dx_c;
    ady_c  = dy_c[32] ? -dy_c : dy_c;
    s_c    = {1'b0, e_r} + {1'b0, ej_r};
    hx_c   = big_r ? {1'b0, ax_r[31:1]} : ax_r;
    hy_c   = big_r ? {1'b0, ay_r[31:1]} : ay_r;
    dist_c = big_r ? {rsp.result[31:0], 1'b0} : {1'b0, rsp.result[31:0]};
    diff_c = {3'b000, rtt_r, 16'h0000} - {2'b00, dist_c};
    esum_c = {1'b0, t1_r} + {1'b0, rsp.result[41:0]};
    mx_c   = rsp.result[53:16];
    gce_c  = (ce_r > GAIN_ONE) ? GAIN_ONE : ce_r;
    gcc_c  = (cc_r > GAIN_ONE) ? GAIN_ONE : cc_r;
  end

  always_comb begin
    req.go = 1'b0;
    req.op = ALU_MUL;
    req.a  = 64'd0;
    req.b  = 64'd0;
    case (state_r)
      S_DIVW: begin
        req.op = ALU_DIV; req.a = {24'd0, e_r, 16'h0000}; req.b = {39'd0, s_c};
      end
      S_SQX:  begin req.a = {32'd0, hx_c}; req.b = {32'd0, hx_c}; end
      S_SQY:  begin req.a = {32'd0, hy_c}; req.b = {32'd0, hy_c}; end
      S_SQRT: begin req.op = ALU_SQRT; req.a = sq_r; end
      S_DIVR: begin req.op = ALU_DIV; req.a = {30'd0, dm_r}; req.b = {48'd0, rtt_r}; end
      S_MCW:  begin req.a = {47'd0, gce_c}; req.b = {47'd0, w_r}; end
      S_ME1:  begin req.a = {40'd0, rel_r}; req.b = {47'd0, cw_r}; end
      S_ME2:  begin req.a = {40'd0, e_r}; req.b = {47'd0, GAIN_ONE - cw_r}; end
      S_MDT:  begin req.a = {47'd0, gcc_c}; req.b = {47'd0, w_r}; end
      S_DUX: begin
        req.op = ALU_DIV; req.a = {16'd0, ax_r, 16'h0000}; req.b = {31'd0, dist_r};
      end
      S_DUY: begin
        req.op = ALU_DIV; req.a = {16'd0, ay_r, 16'h0000}; req.b = {31'd0, dist_r};
      end
      S_MM:   begin req.a = {30'd0, dm_r}; req.b = {47'd0, dt_r}; end
      S_MMX:  begin req.a = {28'd0, m_r}; req.b = {46'd0, ux_r}; end
      S_MMY:  begin req.a = {28'd0, m_r}; req.b = {46'd0, uy_r}; end
      default: ;
    endcase
    if (state_r != S_IDLE && state_r != S_RESP && !(state_r == S_DIVW && s_c == 25'd0))
      req.go = !issued_r;
  end

  ncu_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      x_r      <= COORD_ONE;
      y_r      <= COORD_ONE;
      e_r      <= ERROR_ONE;
      ce_r     <= GAIN_RST;
      cc_r     <= GAIN_RST;
      zero_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.addr == REG_ERROR_GAIN) ce_r <= cfg_ch.data;
        else if (cfg_ch.addr == REG_MOVE_FRACTION) cc_r <= cfg_ch.data;
      end
      if (req.go) issued_r <= 1'b1;
      if (rsp.done) issued_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            rtt_r  <= in_ch.round_trip;
            ej_r   <= in_ch.remote_error;
            dxn_r  <= dx_c[32];
            dyn_r  <= dy_c[32];
            ax_r   <= adx_c[31:0];
            ay_r   <= ady_c[31:0];
            big_r  <= adx_c[31] | ady_c[31];
            zero_r <= (in_ch.round_trip == 16'd0);
            state_r <= (in_ch.round_trip == 16'd0) ? S_RESP : S_DIVW;
          end
        end
        S_DIVW: begin
          if (s_c == 25'd0) begin
            w_r     <= 17'd0;
            state_r <= S_SQX;
          end else if (rsp.done) begin
            w_r     <= rsp.result[16:0];
            state_r <= S_SQX;
          end
        end
        S_SQX: if (rsp.done) begin sq_r <= rsp.result; state_r <= S_SQY; end
        S_SQY: if (rsp.done) begin sq_r <= sq_r + rsp.result; state_r <= S_SQRT; end
        S_SQRT: if (rsp.done) begin
          dist_r  <= dist_c;
          dn_r    <= diff_c[34];
          dm_r    <= diff_c[34] ? 34'(-diff_c) : diff_c[33:0];
          state_r <= S_DIVR;
        end
        S_DIVR: if (rsp.done) begin
          rel_r   <= (|rsp.result[63:24]) ? 24'hFF_FFFF : rsp.result[23:0];
          state_r <= S_MCW;
        end
        S_MCW: if (rsp.done) begin cw_r <= rsp.result[32:16]; state_r <= S_ME1; end
        S_ME1: if (rsp.done) begin t1_r <= rsp.result[41:0]; state_r <= S_ME2; end
        S_ME2: if (rsp.done) begin
          e_r     <= (|esum_c[42:40]) ? 24'hFF_FFFF : esum_c[39:16];
          state_r <= (dist_r == 33'd0) ? S_RESP : S_MDT;
        end
        S_MDT: if (rsp.done) begin dt_r <= rsp.result[32:16]; state_r <= S_DUX; end
        S_DUX: if (rsp.done) begin ux_r <= rsp.result[17:0]; state_r <= S_DUY; end
        S_DUY: if (rsp.done) begin uy_r <= rsp.result[17:0]; state_r <= S_MM; end
        S_MM:  if (rsp.done) begin m_r <= rsp.result[51:16]; state_r <= S_MMX; end
        S_MMX: if (rsp.done) begin
          x_r     <= step_sat(x_r, dn_r ^ dxn_r, mx_c);
          state_r <= S_MMY;
        end
        S_MMY: if (rsp.done) begin
          y_r     <= step_sat(y_r, dn_r ^ dyn_r, mx_c);
          state_r <= S_RESP;
        end
        S_RESP: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = (state_r == S_RESP);
  assign out_ch.local_x     = x_r;
  assign out_ch.local_y     = y_r;
  assign out_ch.local_error = e_r;
  assign out_ch.zero_rtt    = zero_r;

endmodule
`default_nettype wire

### hw/rtl/ncu_checker.sv
// Port-level checks of the coordinate update block
`default_nettype none
`include "assert_macros.svh"
module ncu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] local_x,
  input wire logic [31:0] local_y,
  input wire logic [23:0] local_error
);

  `ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `ASSERT_SAME(a_no_req_while_resp, out_valid, !in_ready)
  `ASSERT_NEXT(a_resp_holds, out_valid && !out_ready,
               out_valid && $stable(local_x) && $stable(local_y) && $stable(local_error))
  `ASSERT_NEXT(a_one_resp, out_valid && out_ready, !out_valid)
  `ASSERT_NEXT_ANY(a_reset_quiet, !rst_n, !out_valid && in_ready)

endmodule

bind network_coordinate_update ncu_checker u_ncu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .local_x    (out_ch.local_x),
  .local_y    (out_ch.local_y),
  .local_error(out_ch.local_error)
);
`default_nettype wire

### test/tb_network_coordinate_update.sv
// Testbench for the 2-D network coordinate update block: directed and random samples
`default_nettype none
module tb_network_coordinate_update;
  import ncu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [23:0] err;
    logic               zero;
  } coord_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int idle_pct = 20;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  ncu_in_if  in_ch();
  ncu_out_if out_ch();
  ncu_cfg_if cfg_ch();

  network_coordinate_update dut(.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
    .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink));

  always #10 clk = ~clk;

  longint unsigned ce_gain, cc_gain;
  longint signed cur_x, cur_y;
  longint unsigned cur_err;
  coord_state_t expected_states[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint signed clamp32(longint signed v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic coord_state_t predict_update(logic [15:0] rtt, logic signed [31:0] rx,
                                                  logic signed [31:0] ry, logic [23:0] ej);
    coord_state_t r;
    longint unsigned ei, s, w, ax, ay, span, relerr, cw, dt, ce, cc;
    longint signed dx, dy, diff, ux, uy, m;
    r.zero = (rtt == 0);
    if (rtt != 0) begin
      ce = (ce_gain > 65536) ? 65536 : ce_gain;
      cc = (cc_gain > 65536) ? 65536 : cc_gain;
      ei = cur_err;
      s = ei + ej;
      w = (s == 0) ? 0 : (ei * 65536) / s;
      dx = cur_x - longint'(rx);
      dy = cur_y - longint'(ry);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
        span = 2 * int_sqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1));
      else
        span = int_sqrt(ax * ax + ay * ay);
      diff = (longint'(rtt) << 16) - longint'(span);
      relerr = longint'(diff < 0 ? -diff : diff) / longint'(rtt);
      if (relerr > 64'hFF_FFFF) relerr = 64'hFF_FFFF;
      cw = (ce * w) >> 16;
      cur_err = (relerr * cw + ei * (65536 - cw)) >> 16;
      if (cur_err > 64'hFF_FFFF) cur_err = 64'hFF_FFFF;
      if (span != 0) begin
        dt = (cc * w) >> 16;
        ux = (dx * 65536) / longint'(span);
        uy = (dy * 65536) / longint'(span);
        m = (diff * longint'(dt)) / 65536;
        cur_x = clamp32(cur_x + (m * ux) / 65536);
        cur_y = clamp32(cur_y + (m * uy) / 65536);
      end
    end
    r.x = cur_x[31:0];
    r.y = cur_y[31:0];
    r.err = cur_err[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic send_sample(logic [15:0] rtt, logic signed [31:0] rx,
                             logic signed [31:0] ry, logic [23:0] ej);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.round_trip <= rtt;
    in_ch.remote_x <= rx;
    in_ch.remote_y <= ry;
    in_ch.remote_error <= ej;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_states.insert(expected_states.size(), predict_update(rtt, rx, ry, ej));
    @(negedge clk);
  endtask

  task automatic drain_results();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (expected_states.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_gain(logic [7:0] idx, logic [16:0] val);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_ERROR_GAIN) ce_gain = val;
    else if (idx == REG_MOVE_FRACTION) cc_gain = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    coord_state_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_states.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_states.pop_front();
        if (out_ch.local_x !== want.x) report_mismatch("local_x", out_ch.local_x, want.x);
        if (out_ch.local_y !== want.y) report_mismatch("local_y", out_ch.local_y, want.y);
        if (out_ch.local_error !== want.err)
          report_mismatch("local_error", out_ch.local_error, want.err);
        if (out_ch.zero_rtt !== want.zero)
          report_mismatch("zero_rtt", out_ch.zero_rtt, want.zero);
      end
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'sd65536 + $signed($urandom_range(2000000)) - 32'sd1000000;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(65536 * 200)) - 32'sd6553600;
    endcase
  endfunction

  task automatic test_directed();
    send_sample(16'd0, 32'sd0, 32'sd0, 24'd0);
    send_sample(16'd1, 32'sd65536, 32'sd65536, 24'd65536);
    send_sample(16'd10, 32'sd0, 32'sd0, 24'd65536);
    send_sample(16'hFFFF, 32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF);
    send_sample(16'd5, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'd0);
    send_sample(16'hFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'd1);
    send_sample(16'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF);
    send_sample(16'd3, 32'sd100000, -32'sd100000, 24'h12_3456);
  endtask

  task automatic test_zero_weight();
    // drive local error to zero, then offer zero remote error
    write_gain(REG_ERROR_GAIN, GAIN_ONE);
    write_gain(REG_MOVE_FRACTION, 17'd0);
    drain_results();
    send_sample(16'd1, cur_x[31:0] + 32'sd65536, cur_y[31:0], 24'd0);
    send_sample(16'd7, 32'sd0, 32'sd0, 24'd0);
    send_sample(16'd2, 32'sd0, 32'sd0, 24'd0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) idle_pct = 0;
      if (i == count / 2) idle_pct = 20;
      if (i % 50 == 25) drain_results();
      send_sample(($urandom_range(9) == 0) ? 16'd0 :
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 200)),
                  rand_coord(), rand_coord(),
                  ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000)));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.round_trip = '0;
    in_ch.remote_x = '0;
    in_ch.remote_y = '0;
    in_ch.remote_error = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    ce_gain = GAIN_RST;
    cc_gain = GAIN_RST;
    cur_x = 65536;
    cur_y = 65536;
    cur_err = 65536;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_zero_weight();
    write_gain(REG_ERROR_GAIN, 17'h1_FFFF);
    write_gain(REG_MOVE_FRACTION, 17'h1_FFFF);
    test_random(150);
    write_gain(8'd2, 17'h0_1234);
    write_gain(REG_ERROR_GAIN, 17'd1);
    write_gain(REG_MOVE_FRACTION, GAIN_ONE);
    test_random(150);
    write_gain(REG_ERROR_GAIN, GAIN_RST);
    write_gain(REG_MOVE_FRACTION, GAIN_RST);
    test_random(250);
    write_gain(REG_ERROR_GAIN, 17'($urandom_range(65536)));
    write_gain(REG_MOVE_FRACTION, 17'($urandom_range(65536)));
    test_random(190);
    drain_results();
    repeat (700) @(negedge clk);
    if (error_count == 0 && expected_states.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
